FILE: sv/spm_pkg.sv
// shared types and constants for the spectrum peak magnitude block
package spm_pkg;

  localparam int TAG_W       = 12;
  localparam int CFG_W       = 4;
  localparam int FRAC_BITS   = 8;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0] LOG2_BINS_RESET = CFG_W'(10);
  localparam logic             REG_LOG2_BINS   = 1'b0;

  typedef struct packed {
    logic               empty;
    logic [LEVEL_W-1:0] level;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_WRITE
  } back_state_t;

endpackage

FILE: sv/spm_front.sv
// front end: bin power, running frame maximum and frame counting
module spm_front #(
  parameter int SAMPLE_BITS   = 16,
  parameter int MAX_LOG2_BINS = 12,
  localparam int LB_W         = $clog2(MAX_LOG2_BINS + 1),
  localparam int PW           = 2 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] bin_real,
  input  logic signed [SAMPLE_BITS-1:0] bin_imag,
  input  logic [spm_pkg::TAG_W-1:0]     range_bin,
  input  logic [LB_W-1:0]               lb_sat,
  input  spm_pkg::queue_stat_t          q_stat,
  output logic                          push,
  output logic [PW-1:0]                 push_power,
  output logic [LB_W-1:0]               push_lb,
  output logic [spm_pkg::TAG_W-1:0]     push_tag
);
  import spm_pkg::*;

  localparam int CNT_W = MAX_LOG2_BINS;
  localparam logic [LB_W-1:0] MAX_LB = LB_W'(MAX_LOG2_BINS);

  logic [SAMPLE_BITS-1:0] re_mag;
  logic [SAMPLE_BITS-1:0] im_mag;
  logic [CNT_W-1:0]       last;
  logic [CNT_W-1:0]       cnt;
  logic                   accept;
  logic                   close;
  logic                   s1_valid;
  logic                   s1_close;
  logic [PW-1:0]          s1_sq_re;
  logic [PW-1:0]          s1_sq_im;
  logic [TAG_W-1:0]       s1_tag;
  logic [LB_W-1:0]        s1_lb;
  logic [PW-1:0]          power;
  logic [PW-1:0]          run_max;
  logic [PW-1:0]          max_next;
  logic [LEVEL_W:0]       credit_used;

  assign re_mag = bin_real[SAMPLE_BITS-1] ? $unsigned(~bin_real + 1'b1) : $unsigned(bin_real);
  assign im_mag = bin_imag[SAMPLE_BITS-1] ? $unsigned(~bin_imag + 1'b1) : $unsigned(bin_imag);

  assign last   = {CNT_W{1'b1}} >> (MAX_LB - lb_sat);
  assign close  = cnt >= last;
  assign accept = in_valid && !in_stall;

  // reserve queue room for a frame result still in flight
  assign credit_used = (LEVEL_W + 1)'(q_stat.level) + (LEVEL_W + 1)'(s1_valid && s1_close);
  assign in_stall    = credit_used >= (LEVEL_W + 1)'(QUEUE_DEPTH);

  assign power    = s1_sq_re + s1_sq_im;
  assign max_next = (power > run_max) ? power : run_max;

  assign push       = s1_valid && s1_close;
  assign push_power = max_next;
  assign push_lb    = s1_lb;
  assign push_tag   = s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      cnt      <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        cnt <= close ? '0 : cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sq_re <= PW'(re_mag) * PW'(re_mag);
      s1_sq_im <= PW'(im_mag) * PW'(im_mag);
      s1_close <= close;
      s1_tag   <= range_bin;
      s1_lb    <= lb_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_max <= '0;
    end else if (s1_valid) begin
      run_max <= s1_close ? '0 : max_next;
    end
  end

  a_clear_after_close: assert property (@(posedge clk) disable iff (rst)
    push |=> run_max == '0)
    else $error("running maximum not cleared after frame close");

  a_max_grows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_close |=> run_max >= $past(run_max))
    else $error("running maximum decreased inside a frame");

endmodule

FILE: sv/spm_queue.sv
// two-entry queue of frame results between front and back
module spm_queue #(
  parameter int DATA_W = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_W-1:0]    push_data,
  input  logic                 pop,
  output logic [DATA_W-1:0]    pop_data,
  output spm_pkg::queue_stat_t stat
);
  import spm_pkg::*;

  logic [DATA_W-1:0]  entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] level;

  assign pop_data   = entries[rd_ptr];
  assign stat.level = level;
  assign stat.empty = level == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level == LEVEL_W'(QUEUE_DEPTH) |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    level == '0 |-> !pop)
    else $error("pop from empty queue");

endmodule

FILE: sv/spm_back.sv
// back end: bit-serial square root, normalizing shift and output register
module spm_back #(
  parameter int SAMPLE_BITS   = 16,
  parameter int MAX_LOG2_BINS = 12,
  localparam int LB_W         = $clog2(MAX_LOG2_BINS + 1),
  localparam int PW           = 2 * SAMPLE_BITS,
  localparam int RW           = SAMPLE_BITS + spm_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  spm_pkg::queue_stat_t      q_stat,
  input  logic [PW-1:0]             q_power,
  input  logic [LB_W-1:0]           q_lb,
  input  logic [spm_pkg::TAG_W-1:0] q_tag,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RW-1:0]             peak_magnitude,
  output logic [spm_pkg::TAG_W-1:0] range_bin_out
);
  import spm_pkg::*;

  localparam int XW     = 2 * RW;
  localparam int STEP_W = $clog2(RW);

  back_state_t       state;
  back_state_t       state_next;
  logic              load_out;
  logic [XW-1:0]     rad;
  logic [RW:0]       rem;
  logic [RW-1:0]     root;
  logic [STEP_W-1:0] step;
  logic [LB_W-1:0]   lb;
  logic [TAG_W-1:0]  tag;
  logic [RW+2:0]     rem_shift;
  logic [RW+2:0]     trial;
  logic              fits;

  assign rem_shift = {rem, rad[XW-1:XW-2]};
  assign trial     = (RW + 3)'({root, 2'b01});
  assign fits      = rem_shift >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = BK_CALC;
        end
      end
      BK_CALC: begin
        if (step == '0) begin
          state_next = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rad  <= {q_power, {(2 * FRAC_BITS){1'b0}}};
      rem  <= '0;
      root <= '0;
      step <= STEP_W'(RW - 1);
      lb   <= q_lb;
      tag  <= q_tag;
    end else if (state == BK_CALC) begin
      rad  <= {rad[XW-3:0], 2'b00};
      rem  <= fits ? (RW + 1)'(rem_shift - trial) : (RW + 1)'(rem_shift);
      root <= {root[RW-2:0], fits};
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      peak_magnitude <= root >> lb;
      range_bin_out  <= tag;
    end
  end

  a_pop_starts_calc: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == BK_CALC)
    else $error("queue pop did not start the square root");

  a_write_shows_word: assert property (@(posedge clk) disable iff (rst)
    state == BK_WRITE && !out_stall |=> out_valid)
    else $error("finished result not presented");

endmodule

FILE: sv/spectrum_peak_magnitude.sv
// top level: spectrum peak magnitude detector with register port
// One bin word is taken per clock while the two-entry result queue has room. The result of
// the bin that closes a frame passes through the front stage into the queue, is popped to load
// the square root unit, which resolves one root bit per clock, and leaves through the output
// register. The square root unit takes one frame result at a time, so frames at least as long
// in bins as one square root pass keep input at one bin per clock while out_stall stays low;
// shorter frames are paced by the square root unit and input is stalled once two frame results
// wait in the queue or in the front stage. log2_bins above MAX_LOG2_BINS is treated as
// MAX_LOG2_BINS. No clearing pass follows reset.
module spectrum_peak_magnitude #(
  parameter int SAMPLE_BITS   = 16,
  parameter int MAX_LOG2_BINS = 12
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [spm_pkg::PADDR_W-1:0]                 paddr,
  input  logic [spm_pkg::PDATA_W-1:0]                 pwdata,
  output logic [spm_pkg::PDATA_W-1:0]                 prdata,
  output logic                                        pready,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic signed [SAMPLE_BITS-1:0]               bin_real,
  input  logic signed [SAMPLE_BITS-1:0]               bin_imag,
  input  logic [spm_pkg::TAG_W-1:0]                   range_bin,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [SAMPLE_BITS+spm_pkg::FRAC_BITS-1:0]   peak_magnitude,
  output logic [spm_pkg::TAG_W-1:0]                   range_bin_out
);
  import spm_pkg::*;

  localparam int LB_W   = $clog2(MAX_LOG2_BINS + 1);
  localparam int PW     = 2 * SAMPLE_BITS;
  localparam int DATA_W = LB_W + TAG_W + PW;
  localparam logic [LB_W-1:0] MAX_LB = LB_W'(MAX_LOG2_BINS);

  logic [CFG_W-1:0]  log2_bins;
  logic [LB_W-1:0]   lb_sat;
  queue_stat_t       q_stat;
  logic              push;
  logic [PW-1:0]     push_power;
  logic [LB_W-1:0]   push_lb;
  logic [TAG_W-1:0]  push_tag;
  logic              pop;
  logic [DATA_W-1:0] pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOG2_BINS) ? PDATA_W'(log2_bins) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_bins <= LOG2_BINS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LOG2_BINS) begin
      log2_bins <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (int'(log2_bins) > MAX_LOG2_BINS) begin
      lb_sat = MAX_LB;
    end else begin
      lb_sat = LB_W'(log2_bins);
    end
  end

  spm_front #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .MAX_LOG2_BINS (MAX_LOG2_BINS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .bin_real   (bin_real),
    .bin_imag   (bin_imag),
    .range_bin  (range_bin),
    .lb_sat     (lb_sat),
    .q_stat     (q_stat),
    .push       (push),
    .push_power (push_power),
    .push_lb    (push_lb),
    .push_tag   (push_tag)
  );

  spm_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_lb, push_tag, push_power}),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  spm_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .MAX_LOG2_BINS (MAX_LOG2_BINS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .q_power        (pop_data[PW-1:0]),
    .q_lb           (pop_data[DATA_W-1:PW+TAG_W]),
    .q_tag          (pop_data[PW+TAG_W-1:PW]),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .peak_magnitude (peak_magnitude),
    .range_bin_out  (range_bin_out)
  );

endmodule

FILE: tb/sv/testbench.sv
// testbench for spectrum_peak_magnitude: directed table, then random frames checked by a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spm_pkg::*;

  localparam int SAMPLE_W       = 16;
  localparam int MAX_LOG2       = 12;
  localparam int FULL_LOG2      = 8;
  localparam int MAG_W          = SAMPLE_W + FRAC_BITS;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BINS     = 56;
  localparam logic [PADDR_W-1:0] LOG2_BINS_ADDR = PADDR_W'(4 * int'(REG_LOG2_BINS));

  typedef enum logic [1:0] {
    ROW_READ,
    ROW_WRITE,
    ROW_BIN
  } row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [31:0]         value;
    logic signed [15:0]  re;
    logic signed [15:0]  im;
    logic [TAG_W-1:0]    tag;
    bit                  typed;
    logic [MAG_W-1:0]    want;
  } dir_row_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [TAG_W-1:0] tag;
  } peak_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] bin_real = '0;
  logic signed [SAMPLE_W-1:0] bin_imag = '0;
  logic [TAG_W-1:0] range_bin = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MAG_W-1:0] peak_magnitude;
  logic [TAG_W-1:0] range_bin_out;

  logic [CFG_W-1:0] shadow_log2_bins = LOG2_BINS_RESET;
  logic [31:0]      frame_max_power = '0;
  int               frame_bin_idx = 0;
  peak_word_t       pending_peaks[$];
  peak_word_t       head_peak;

  int err_count = 0;
  int bins_sent = 0;
  int peaks_checked = 0;
  int cfg_writes = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int stall_cycles = 0;

  dir_row_t dir_rows [26] = '{
    '{ROW_READ,  32'd10, 16'sd0,     16'sd0,     12'd0,    1'b1, 24'd0},
    '{ROW_WRITE, 32'd0,  16'sd0,     16'sd0,     12'd0,    1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  16'sd0,     16'sd0,     12'd0,    1'b1, 24'd0},
    '{ROW_BIN,   32'd0,  16'sh8000,  16'sh8000,  12'd4095, 1'b1, 24'd11863283},
    '{ROW_BIN,   32'd0,  16'sd32767, 16'sd32767, 12'd1,    1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  16'sh8000,  16'sd0,     12'd2,    1'b1, 24'd8388608},
    '{ROW_BIN,   32'd0,  16'sd0,     16'sd32767, 12'd3,    1'b1, 24'd8388352},
    '{ROW_BIN,   32'd0,  16'sd3,     -16'sd4,    12'd4,    1'b1, 24'd1280},
    '{ROW_BIN,   32'd0,  -16'sd1,    16'sd0,     12'd5,    1'b1, 24'd256},
    '{ROW_READ,  32'd0,  16'sd0,     16'sd0,     12'd0,    1'b1, 24'd0},
    '{ROW_WRITE, 32'd2,  16'sd0,     16'sd0,     12'd0,    1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  16'sd3,     16'sd4,     12'd16,   1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  16'sd4,     16'sd3,     12'd17,   1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  -16'sd5,    16'sd0,     12'd18,   1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  16'sd0,     -16'sd5,    12'd19,   1'b1, 24'd320},
    '{ROW_BIN,   32'd0,  16'sd1,     16'sd1,     12'd20,   1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  16'sd2,     -16'sd2,    12'd21,   1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  -16'sd3,    16'sd3,     12'd22,   1'b0, 24'd0},
    '{ROW_WRITE, 32'd1,  16'sd0,     16'sd0,     12'd0,    1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  16'sd0,     16'sd0,     12'd23,   1'b0, 24'd0},
    '{ROW_WRITE, 32'd15, 16'sd0,     16'sd0,     12'd0,    1'b0, 24'd0},
    '{ROW_READ,  32'd15, 16'sd0,     16'sd0,     12'd0,    1'b1, 24'd0},
    '{ROW_BIN,   32'd0,  16'sd100,   -16'sd200,  12'd2730, 1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  -16'sd300,  16'sd400,   12'd1365, 1'b0, 24'd0},
    '{ROW_WRITE, 32'd0,  16'sd0,     16'sd0,     12'd0,    1'b0, 24'd0},
    '{ROW_BIN,   32'd0,  16'sd0,     16'sd0,     12'd4095, 1'b1, 24'd128000}
  };

  spectrum_peak_magnitude u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [24:0] root_floor(input logic [47:0] x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= 64'(x)) r = t;
    end
    return 25'(r);
  endfunction

  // folds one bin into the frame peak; returns 1 when the bin closes the frame
  function automatic bit predict_bin(input logic signed [15:0] re, input logic signed [15:0] im,
                                     input logic [TAG_W-1:0] tag, output peak_word_t res);
    logic [16:0] ar;
    logic [16:0] ai;
    logic [31:0] pwr;
    int          lb;
    ar  = (re < 0) ? 17'(-int'(re)) : 17'(re);
    ai  = (im < 0) ? 17'(-int'(im)) : 17'(im);
    pwr = 32'(ar) * 32'(ar) + 32'(ai) * 32'(ai);
    res = '0;
    if (pwr > frame_max_power) frame_max_power = pwr;
    lb = (int'(shadow_log2_bins) > MAX_LOG2) ? MAX_LOG2 : int'(shadow_log2_bins);
    if (frame_bin_idx >= (1 << lb) - 1) begin
      res.mag = MAG_W'(root_floor({frame_max_power, 16'd0}) >> lb);
      res.tag = tag;
      frame_max_power = '0;
      frame_bin_idx = 0;
      return 1'b1;
    end
    frame_bin_idx++;
    return 1'b0;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sd32767;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      1: return 16'($signed(5'($urandom)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_log2_bins();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CFG_W'($urandom_range(0, 4));
    if (r < 9) return CFG_W'($urandom_range(5, 8));
    return CFG_W'($urandom_range(9, 15));
  endfunction

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_log2_bins(input logic [PDATA_W-1:0] data);
    apb_write(LOG2_BINS_ADDR, data);
    shadow_log2_bins = data[CFG_W-1:0];
    cfg_writes++;
  endtask

  task automatic check_log2_bins(input logic [PDATA_W-1:0] want);
    logic [PDATA_W-1:0] rd;
    apb_read(LOG2_BINS_ADDR, rd);
    if (rd !== want) begin
      $error("log2_bins readback: expected %0d, actual %0d", want, rd);
      err_count++;
    end
  endtask

  task automatic wait_drained(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_peaks.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_bin(input logic signed [15:0] re, input logic signed [15:0] im,
                          input logic [TAG_W-1:0] tag, input bit typed,
                          input logic [MAG_W-1:0] want);
    peak_word_t res;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    bin_real <= re;
    bin_imag <= im;
    range_bin <= tag;
    do @(posedge clk); while (in_stall);
    bins_sent++;
    if (predict_bin(re, im, tag, res)) begin
      if (typed) res.mag = want;
      pending_peaks.insert(pending_peaks.size(), res);
    end
  endtask

  task automatic run_setting(input logic [CFG_W-1:0] lb, input int count);
    logic [PDATA_W-1:0] data;
    wait_drained(1'b1);
    data = {28'($urandom), lb};
    set_log2_bins(data);
    check_log2_bins(PDATA_W'(lb));
    repeat (count) begin
      if ($urandom_range(0, 99) == 0) wait_drained(1'b0);
      send_bin(rand_sample(), rand_sample(), TAG_W'($urandom), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_peaks.size() == 0) begin
        $error("peak word with none expected: peak_magnitude %0d range_bin_out %0d",
               peak_magnitude, range_bin_out);
        err_count++;
      end else begin
        head_peak = pending_peaks.pop_front();
        peaks_checked++;
        if (peak_magnitude !== head_peak.mag) begin
          $error("peak_magnitude: expected %0d, actual %0d", head_peak.mag, peak_magnitude);
          err_count++;
        end
        if (range_bin_out !== head_peak.tag) begin
          $error("range_bin_out: expected %0d, actual %0d", head_peak.tag, range_bin_out);
          err_count++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d peaks outstanding",
                 WATCHDOG_LIMIT, pending_peaks.size());
        $display("** spectrum_peak_magnitude: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_READ: begin
          wait_drained(1'b1);
          check_log2_bins(dir_rows[i].value);
        end
        ROW_WRITE: begin
          wait_drained(1'b1);
          set_log2_bins(dir_rows[i].value);
        end
        default: begin
          send_bin(dir_rows[i].re, dir_rows[i].im, dir_rows[i].tag, dir_rows[i].typed,
                   dir_rows[i].want);
        end
      endcase
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_gap_pct = 32;
          recv_stall_pct = 53;
        end
        1: begin
          send_gap_pct = 53;
          recv_stall_pct = 32;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 4; ph++) run_setting(pick_log2_bins(), PHASE_BINS);
    end

    // a long run at a mid frame size
    run_setting(CFG_W'(FULL_LOG2), (1 << FULL_LOG2) + 3);

    wait_drained(1'b1);
    $display("run covered %0d bins and %0d frame peaks over %0d log2_bins writes,",
             bins_sent, peaks_checked, cfg_writes);
    $display("including saturated and mid-frame size changes and three idle patterns");
    if (err_count == 0) begin
      $display("** spectrum_peak_magnitude: PASSED **");
    end else begin
      $display("** spectrum_peak_magnitude: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/spm_pkg.sv
sv/spm_front.sv
sv/spm_queue.sv
sv/spm_back.sv
sv/spectrum_peak_magnitude.sv
tb/sv/testbench.sv
